>>> design/deq_pkg.sv
package deq_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int ITEM_WIDTH_DEF = 32;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_INSPECT    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] item_value;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] front_item;
		logic [31:0] back_item;
		logic        is_empty;
		logic [8:0]  item_count;
	} rsp_word_t;

	typedef struct packed {
		logic exec;
		logic capture;
	} deq_cmd_t;

	typedef struct packed {
		logic rsp_busy;
	} deq_stat_t;

endpackage

>>> design/deq_ram.sv
module deq_ram #(
	parameter int WIDTH = deq_pkg::ITEM_WIDTH_DEF,
	parameter int DEPTH = deq_pkg::CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> design/deq_ctrl.sv
module deq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  deq_pkg::deq_stat_t  stat,
	output deq_pkg::deq_cmd_t   cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_CAPT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_ready   = (state_q == S_IDLE);
	assign cmd.exec    = req_ready && req_valid;
	assign cmd.capture = (state_q == S_CAPT) && !stat.rsp_busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.exec) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_CAPT;
			end
			S_CAPT: begin
				if (cmd.capture) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_exec_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> state_q == S_READ)
		else $error("exec did not advance to read");

	a_read_to_capt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_CAPT && !req_ready)
		else $error("read did not advance to capture");

endmodule

>>> design/deq_datapath.sv
module deq_datapath #(
	parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
	parameter int ITEM_WIDTH = deq_pkg::ITEM_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  deq_pkg::deq_cmd_t   cmd,
	output deq_pkg::deq_stat_t  stat,
	input  deq_pkg::req_word_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output deq_pkg::rsp_word_t  rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [IDX_W-1:0] front_q, back_q, front_d, back_d, waddr;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       status_q, status_d;
	logic             we;
	logic             full, empty, is_push, is_pop;

	logic [ITEM_WIDTH+31:0] wext;
	logic [ITEM_WIDTH-1:0]  wdata, rdata_f, rdata_b;
	logic [ITEM_WIDTH+31:0] fext, bext;
	logic [CNT_W+8:0]       cext;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
	endfunction

	assign wext  = {{ITEM_WIDTH{1'b0}}, req.item_value};
	assign wdata = wext[ITEM_WIDTH-1:0];

	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign empty   = (cnt_q == '0);
	assign is_push = (req.command == deq_pkg::CMD_PUSH_FRONT)
		|| (req.command == deq_pkg::CMD_PUSH_BACK);
	assign is_pop  = (req.command == deq_pkg::CMD_POP_FRONT)
		|| (req.command == deq_pkg::CMD_POP_BACK);

	always_comb begin
		front_d  = front_q;
		back_d   = back_q;
		cnt_d    = cnt_q;
		status_d = deq_pkg::ST_OK;
		we       = 1'b0;
		waddr    = front_q;
		if (is_push) begin
			if (full) begin
				status_d = deq_pkg::ST_FULL;
			end else begin
				if (empty) begin
					back_d = front_q;
				end else if (req.command == deq_pkg::CMD_PUSH_FRONT) begin
					front_d = ring_prev(front_q);
				end else begin
					back_d = ring_next(back_q);
				end
				waddr = (req.command == deq_pkg::CMD_PUSH_FRONT) ? front_d : back_d;
				we    = cmd.exec;
				cnt_d = cnt_q + 1'b1;
			end
		end else if (is_pop) begin
			if (empty) begin
				status_d = deq_pkg::ST_EMPTY;
			end else begin
				if (cnt_q != CNT_W'(1)) begin
					if (req.command == deq_pkg::CMD_POP_FRONT) begin
						front_d = ring_next(front_q);
					end else begin
						back_d = ring_prev(back_q);
					end
				end
				cnt_d = cnt_q - 1'b1;
			end
		end else begin
			if (empty) status_d = deq_pkg::ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			cnt_q   <= '0;
		end else if (cmd.exec) begin
			front_q <= front_d;
			back_q  <= back_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) status_q <= status_d;
	end

	deq_ram #(
		.WIDTH (ITEM_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (front_q),
		.raddr_b (back_q),
		.rdata_a (rdata_f),
		.rdata_b (rdata_b)
	);

	assign fext = {32'd0, rdata_f};
	assign bext = {32'd0, rdata_b};
	assign cext = {9'd0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.capture) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rsp.status     <= status_q;
			rsp.front_item <= empty ? 32'd0 : fext[31:0];
			rsp.back_item  <= empty ? 32'd0 : bext[31:0];
			rsp.is_empty   <= empty;
			rsp.item_count <= cext[8:0];
		end
	end

	assign stat.rsp_busy = rsp_valid && !rsp_ready;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("count exceeds capacity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !(rsp_valid && !rsp_ready))
		else $error("pending word overwritten");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> rsp.front_item == 32'd0
			&& rsp.back_item == 32'd0 && rsp.item_count == 9'd0)
		else $error("empty word carries items");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && status_d == deq_pkg::ST_FULL |-> !we)
		else $error("write on full queue");

endmodule

>>> design/double_ended_queue_unit.sv
// channel  dir  handshake             payload
// req      in   req_valid/req_ready   deq_pkg::req_word_t (command, item_value)
// rsp      out  rsp_valid/rsp_ready   deq_pkg::rsp_word_t (status, items, count)
//
// Each word passes through three steps: execute and store write, store read of the new
// front and back entries, capture into the response register.
// The store read step is there because the store's read port is registered.
// A new word is taken while the previous response still waits; capture holds
// until the response register is free.
// Reset clears indexes, count and control; the store is not cleared.
module double_ended_queue_unit #(
	parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
	parameter int ITEM_WIDTH = deq_pkg::ITEM_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  deq_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output deq_pkg::rsp_word_t rsp
);

	deq_pkg::deq_cmd_t  cmd;
	deq_pkg::deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_datapath #(
		.CAPACITY   (CAPACITY),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
